[hw/rtl/glcd_psc_pkg.sv]
// shared types and constants for the graphic lcd pixel set/clear engine
// no dependencies; used by the controller, datapath and top level
package glcd_psc_pkg;

    // request opcode carried on the slave tuser
    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // controller command kinds carried on the master tuser
    localparam logic [1:0] KIND_HALF = 2'd0;
    localparam logic [1:0] KIND_PAGE = 2'd1;
    localparam logic [1:0] KIND_COL  = 2'd2;
    localparam logic [1:0] KIND_DATA = 2'd3;

    // pixels per byte and columns per panel half
    localparam int unsigned BYTE_ROWS  = 8;
    localparam int unsigned HALF_WIDTH = 64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_MODIFY,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic load;
        logic wr_en;
        logic beat_clr;
        logic beat_adv;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic in_range;
        logic skip;
        logic beat_last;
    } t_dp_stat;

endpackage

[hw/rtl/glcd_psc_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module glcd_psc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/glcd_psc_ctrl.sv]
// controller state machine: clearing sweep, request intake, lookup, modify, beat emission
// depends on glcd_psc_pkg
module glcd_psc_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    input  glcd_psc_pkg::t_dp_stat i_stat,
    output glcd_psc_pkg::t_dp_cmd  o_cmd
);

    import glcd_psc_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = i_stat.in_range ? ST_MODIFY : ST_IDLE;
            end
            ST_MODIFY: begin
                n_state = i_stat.skip ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (i_m_tready && i_stat.beat_last) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_LOOKUP: begin
                o_cmd = '0;
            end
            ST_MODIFY: begin
                o_cmd.wr_en    = !i_stat.skip;
                o_cmd.beat_clr = !i_stat.skip;
            end
            ST_EMIT: begin
                o_m_tvalid     = 1'b1;
                o_cmd.beat_adv = i_m_tready;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[hw/rtl/glcd_psc_dp.sv]
// datapath: request registers, address and mask decode, shadow ram, clearing counter, beat mux
// depends on glcd_psc_pkg and glcd_psc_ram
module glcd_psc_dp #(
    parameter int unsigned COLUMNS = 128,
    parameter int unsigned PAGES   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd,
    input  logic [7:0]             i_px,
    input  logic [7:0]             i_py,
    input  glcd_psc_pkg::t_dp_cmd  i_ctl,
    output glcd_psc_pkg::t_dp_stat o_stat,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_value,
    output logic                   o_last
);

    import glcd_psc_pkg::*;

    localparam int unsigned ROWS  = PAGES * BYTE_ROWS;
    localparam int unsigned DEPTH = PAGES * COLUMNS;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic          r_cmd;
    logic [7:0]    r_x;
    logic [7:0]    r_y;
    logic [7:0]    r_byte;
    logic [1:0]    r_beat;
    logic [AW-1:0] r_clr_addr;

    logic [7:0]    w_row;
    logic [7:0]    w_page;
    logic [7:0]    w_mask;
    logic [15:0]   w_idx_full;
    logic [AW-1:0] w_idx;
    logic [7:0]    w_rd_data;
    logic [7:0]    w_new_byte;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [7:0]    w_ram_wdata;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_x   <= i_px;
            r_y   <= i_py;
        end
        if (i_ctl.wr_en) begin
            r_byte <= w_new_byte;
        end
    end

    // flipped row, page, bit mask and shadow index
    assign w_row      = 8'(ROWS - 1) - r_y;
    assign w_page     = {3'b000, w_row[7:3]};
    assign w_mask     = 8'h01 << w_row[2:0];
    assign w_idx_full = 16'(w_page) * 16'(COLUMNS) + 16'(r_x);
    assign w_idx      = w_idx_full[AW-1:0];

    // range check and read-modify of the shadow byte
    assign o_stat.in_range = (9'(r_x) < 9'(COLUMNS)) && (9'(r_y) < 9'(ROWS));
    assign o_stat.skip     = (r_cmd == CMD_SET) && ((w_rd_data & w_mask) == w_mask);
    assign w_new_byte      = (r_cmd == CMD_SET) ? (w_rd_data | w_mask)
                                                : (w_rd_data & ~w_mask);

    // clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctl.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end
    assign o_stat.clr_done = (r_clr_addr == AW'(DEPTH - 1));

    // beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (i_ctl.beat_clr) begin
            r_beat <= '0;
        end else if (i_ctl.beat_adv) begin
            r_beat <= r_beat + 1'b1;
        end
    end
    assign o_stat.beat_last = (r_beat == KIND_DATA);

    // ram write port is shared by the sweep and the update
    assign w_ram_we    = i_ctl.clr_en | i_ctl.wr_en;
    assign w_ram_waddr = i_ctl.clr_en ? r_clr_addr : w_idx;
    assign w_ram_wdata = i_ctl.clr_en ? 8'h00 : w_new_byte;

    glcd_psc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_shadow (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_addr (w_idx),
        .o_rd_data (w_rd_data)
    );

    // beat payload select
    always_comb begin
        o_kind = r_beat;
        o_last = 1'b0;
        case (r_beat)
            KIND_HALF: o_value = {6'b0, r_x[7:6]};
            KIND_PAGE: o_value = w_page;
            KIND_COL:  o_value = {2'b0, r_x[5:0]};
            KIND_DATA: begin
                o_value = r_byte;
                o_last  = 1'b1;
            end
            default:   o_value = 8'h00;
        endcase
    end

endmodule

[hw/rtl/glcd_pixel_set_clear_shadow_top.sv]
// pixel set/clear engine for a two-half graphic lcd, keeping a shadow of the panel
// a request is taken while idle, then looked up and range-checked, then modified in
// the shadow; its four command beats follow one per cycle while m_tready is high.
// out-of-range requests are dropped, sets of set pixels skipped; one request at a time
// reset clears the shadow ram with a sweep of all PAGES*COLUMNS bytes (1024 by default)
// during which no request is taken
module glcd_pixel_set_clear_shadow_top #(
    parameter int unsigned COLUMNS = 128,
    parameter int unsigned PAGES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // px [7:0], py [15:8]
    input  logic [0:0]  s_tuser,   // cmd [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // value [7:0]
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast
);

    import glcd_psc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    glcd_psc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    glcd_psc_dp #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_tuser[0]),
        .i_px    (s_tdata[7:0]),
        .i_py    (s_tdata[15:8]),
        .i_ctl   (w_cmd),
        .o_stat  (w_stat),
        .o_kind  (m_tuser),
        .o_value (m_tdata),
        .o_last  (m_tlast)
    );

endmodule
